// ----- rtl/sfd_pkg.sv -----
// Shared types, constants and the CRC16-CCITT-FALSE byte update for the frame checker.
// No dependencies; compile first.
package sfd_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] MinFrameIdx = CountW'(11);  // index of 12th byte
  localparam logic [CountW-1:0] CrcOffset = CountW'(8);     // 2 magic + 2 length + 4 header

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0] Magic0 = 8'hAA;
  localparam logic [7:0] Magic1 = 8'h55;
  localparam logic [7:0] End0 = 8'h0D;
  localparam logic [7:0] End1 = 8'h0A;

  // Role of a byte inside the frame, decided from its position.
  typedef enum logic [3:0] {
    KindMagic0,
    KindMagic1,
    KindLenLo,
    KindLenHi,
    KindHeader,
    KindPayload,
    KindCrcLo,
    KindCrcHi,
    KindEnd0,
    KindEnd1,
    KindOther
  } byte_kind_e;

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusShort    = 3'd1,
    StatusMagic    = 3'd2,
    StatusLength   = 3'd3,
    StatusEndMark  = 3'd4,
    StatusCrc      = 3'd5
  } status_e;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] data;
    byte_kind_e kind;
    logic [1:0] hdr_sel;
    logic       last;
    logic       too_short;
    logic       len_match;
  } byte_item_t;

  typedef struct packed {
    status_e     status;
    logic        header_valid;
    logic [15:0] payload_len;
    logic [31:0] header_word;
    logic [15:0] rx_crc;
    logic [15:0] computed_crc;
  } verdict_t;

  // MSB-first CRC update over one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/sfd_byte_if.sv -----
// Byte channel into the frame checker: valid/ready handshake with data and last flag.
// No dependencies.
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/sfd_verdict_if.sv -----
// Verdict channel out of the frame checker: valid/ready handshake with the result fields.
// No dependencies.
interface sfd_verdict_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        header_valid;
  logic [15:0] payload_len;
  logic [7:0]  priority_res;
  logic [7:0]  msg_id;
  logic [7:0]  sequence_res;
  logic [7:0]  header_flags;
  logic [15:0] rx_crc;
  logic [15:0] computed_crc;

  modport source (output valid, output status, output header_valid, output payload_len,
                  output priority_res, output msg_id, output sequence_res,
                  output header_flags, output rx_crc, output computed_crc,
                  input ready);
  modport sink (input valid, input status, input header_valid, input payload_len,
                input priority_res, input msg_id, input sequence_res,
                input header_flags, input rx_crc, input computed_crc,
                output ready);
endinterface

// ----- rtl/sfd_front.sv -----
// Front end: counts frame bytes, tracks the declared length and tags each byte with its role.
// Depends on sfd_pkg.
module sfd_front
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  input  logic       push_ready_i,
  output logic       push_valid_o,
  output byte_item_t item_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [15:0]       len_q, len_d;
  logic [CountW-1:0] crc_end;
  logic              push;

  assign push         = valid_i && push_ready_i;
  assign push_valid_o = valid_i;
  assign crc_end      = {1'b0, len_q} + CrcOffset;

  always_comb begin
    item_o.data      = data_i;
    item_o.last      = last_i;
    item_o.hdr_sel   = count_q[1:0];
    item_o.too_short = count_q < MinFrameIdx;
    item_o.len_match = count_q == (crc_end + CountW'(3));
    if (count_q == CountW'(0)) begin
      item_o.kind = KindMagic0;
    end else if (count_q == CountW'(1)) begin
      item_o.kind = KindMagic1;
    end else if (count_q == CountW'(2)) begin
      item_o.kind = KindLenLo;
    end else if (count_q == CountW'(3)) begin
      item_o.kind = KindLenHi;
    end else if (count_q < CrcOffset) begin
      item_o.kind = KindHeader;
    end else if (count_q < crc_end) begin
      item_o.kind = KindPayload;
    end else if (count_q == crc_end) begin
      item_o.kind = KindCrcLo;
    end else if (count_q == crc_end + CountW'(1)) begin
      item_o.kind = KindCrcHi;
    end else if (count_q == crc_end + CountW'(2)) begin
      item_o.kind = KindEnd0;
    end else if (count_q == crc_end + CountW'(3)) begin
      item_o.kind = KindEnd1;
    end else begin
      item_o.kind = KindOther;
    end
  end

  always_comb begin
    count_d = count_q;
    len_d   = len_q;
    if (push) begin
      if (last_i) begin
        count_d = '0;
        len_d   = '0;
      end else begin
        if (count_q != CountMax) begin
          count_d = count_q + CountW'(1);
        end
        if (count_q == CountW'(2)) begin
          len_d[7:0] = data_i;
        end
        if (count_q == CountW'(3)) begin
          len_d[15:8] = data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= '0;
    end else begin
      count_q <= count_d;
      len_q   <= len_d;
    end
  end

endmodule

// ----- rtl/sfd_queue.sv -----
// Two-entry queue of classified bytes between the front and back ends.
// Depends on sfd_pkg.
module sfd_queue
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  byte_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output byte_item_t pop_item_o
);

  byte_item_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_ready_o = fill_q != 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/sfd_back.sv -----
// Back end: runs the CRC, captures length, header and trailer, and registers one verdict per frame.
// Depends on sfd_pkg.
module sfd_back
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  byte_item_t item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output verdict_t   verdict_o
);

  logic [15:0] crc_q, crc_u, crc_d;
  logic [15:0] len_q, len_u, len_d;
  logic [31:0] hdr_q, hdr_u, hdr_d;
  logic [15:0] fcrc_q, fcrc_u, fcrc_d;
  logic [15:0] snap_q, snap_u, snap_d;
  logic        magic_ok_q, magic_ok_u, magic_ok_d;
  logic        end_ok_q, end_ok_u, end_ok_d;
  logic        out_valid_q;
  verdict_t    out_q, verdict;
  logic        pop;

  // A non-final byte never blocks; the final one waits for a free output register.
  assign pop_ready_o = !item_i.last || !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    crc_u      = crc_q;
    len_u      = len_q;
    hdr_u      = hdr_q;
    fcrc_u     = fcrc_q;
    snap_u     = snap_q;
    magic_ok_u = magic_ok_q;
    end_ok_u   = end_ok_q;
    if (item_i.kind inside {KindLenLo, KindLenHi, KindHeader, KindPayload}) begin
      crc_u = crc_byte(crc_q, item_i.data);
    end
    unique case (item_i.kind)
      KindMagic0: if (item_i.data != Magic0) magic_ok_u = 1'b0;
      KindMagic1: if (item_i.data != Magic1) magic_ok_u = 1'b0;
      KindLenLo:  len_u[7:0] = item_i.data;
      KindLenHi:  len_u[15:8] = item_i.data;
      KindHeader: begin
        case (item_i.hdr_sel)
          2'd0:    hdr_u[7:0]   = item_i.data;
          2'd1:    hdr_u[15:8]  = item_i.data;
          2'd2:    hdr_u[23:16] = item_i.data;
          default: hdr_u[31:24] = item_i.data;
        endcase
      end
      KindCrcLo: begin
        snap_u      = crc_q;
        fcrc_u[7:0] = item_i.data;
      end
      KindCrcHi:  fcrc_u[15:8] = item_i.data;
      KindEnd0:   if (item_i.data != End0) end_ok_u = 1'b0;
      KindEnd1:   if (item_i.data != End1) end_ok_u = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    status_e st;
    logic    hv, cv;
    if (item_i.too_short) begin
      st = StatusShort;
    end else if (!magic_ok_u) begin
      st = StatusMagic;
    end else if (!item_i.len_match) begin
      st = StatusLength;
    end else if (!end_ok_u) begin
      st = StatusEndMark;
    end else if (fcrc_u != snap_u) begin
      st = StatusCrc;
    end else begin
      st = StatusOk;
    end
    hv = !(st == StatusShort || st == StatusMagic);
    cv = st == StatusOk || st == StatusCrc;
    verdict.status       = st;
    verdict.header_valid = hv;
    verdict.payload_len  = hv ? len_u : '0;
    verdict.header_word  = hv ? hdr_u : '0;
    verdict.rx_crc       = cv ? fcrc_u : '0;
    verdict.computed_crc = cv ? snap_u : '0;
  end

  always_comb begin
    crc_d      = crc_q;
    len_d      = len_q;
    hdr_d      = hdr_q;
    fcrc_d     = fcrc_q;
    snap_d     = snap_q;
    magic_ok_d = magic_ok_q;
    end_ok_d   = end_ok_q;
    if (pop) begin
      if (item_i.last) begin
        crc_d      = CrcInit;
        len_d      = '0;
        hdr_d      = '0;
        fcrc_d     = '0;
        snap_d     = '0;
        magic_ok_d = 1'b1;
        end_ok_d   = 1'b1;
      end else begin
        crc_d      = crc_u;
        len_d      = len_u;
        hdr_d      = hdr_u;
        fcrc_d     = fcrc_u;
        snap_d     = snap_u;
        magic_ok_d = magic_ok_u;
        end_ok_d   = end_ok_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      len_q       <= '0;
      hdr_q       <= '0;
      fcrc_q      <= '0;
      snap_q      <= '0;
      magic_ok_q  <= 1'b1;
      end_ok_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      len_q      <= len_d;
      hdr_q      <= hdr_d;
      fcrc_q     <= fcrc_d;
      snap_q     <= snap_d;
      magic_ok_q <= magic_ok_d;
      end_ok_q   <= end_ok_d;
      if (pop && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_q;

endmodule

// ----- rtl/serial_frame_deframer_crc16.sv -----
// Framed packet checker: one byte per transaction in, one verdict per frame out.
// Depends on sfd_pkg, sfd_byte_if, sfd_verdict_if, sfd_front, sfd_queue, sfd_back.
//
// Feed the bytes of a received frame in order on byte_i, with last_byte set on the
// final byte; each frame produces exactly one verdict transaction on verdict_o. The
// frame is AA 55, a little-endian 16-bit payload length L, a 32-bit little-endian
// header, L payload bytes, a little-endian CRC16-CCITT-FALSE over everything from
// the length field to the end of the payload, and the end marker 0D 0A. Checks are
// reported in priority order: too short (under 12 bytes), bad magic, length mismatch
// (size not L+12; the byte counter saturates at 2^17-1, so very long frames land
// here), bad end marker, CRC mismatch. Header fields are zero unless the size and
// magic checks passed; both CRC fields are zero unless length and end marker passed.
// Rate: one byte per clock cycle while verdict_o keeps up, set by the byte-wide
// CRC update in the back end. A byte is written into the two-entry queue when
// accepted, then the back end pops and processes it; popping the final byte also
// registers the verdict, and that pop waits while verdict_o holds an untaken one.
// byte_i.ready drops only while the queue is full, which happens when a finished
// verdict is held by a stalled verdict_o consumer.
module serial_frame_deframer_crc16
  import sfd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sfd_byte_if.sink      byte_i,
  sfd_verdict_if.source verdict_o
);

  // Classified byte from the front end and its queue handshake.
  byte_item_t push_item, pop_item;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  verdict_t   verdict;

  // Front: count bytes, track the declared length, tag each byte's role.
  sfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (byte_i.valid),
    .data_i       (byte_i.data_byte),
    .last_i       (byte_i.last_byte),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .item_o       (push_item)
  );

  // Accept a byte whenever the queue has room.
  assign byte_i.ready = push_ready;

  // Decouple front and back so each can stall on its own.
  sfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back: run the CRC, capture fields and register the verdict.
  sfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .item_i      (pop_item),
    .out_valid_o (verdict_o.valid),
    .out_ready_i (verdict_o.ready),
    .verdict_o   (verdict)
  );

  // Split the header word into its byte fields.
  assign verdict_o.status       = verdict.status;
  assign verdict_o.header_valid = verdict.header_valid;
  assign verdict_o.payload_len  = verdict.payload_len;
  assign verdict_o.priority_res = verdict.header_word[31:24];
  assign verdict_o.msg_id       = verdict.header_word[23:16];
  assign verdict_o.sequence_res = verdict.header_word[15:8];
  assign verdict_o.header_flags = verdict.header_word[7:0];
  assign verdict_o.rx_crc       = verdict.rx_crc;
  assign verdict_o.computed_crc = verdict.computed_crc;

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for serial_frame_deframer_crc16: drives frames byte by byte and
// checks each verdict against an internal frame checker model.
// Depends on sfd_pkg, sfd_byte_if, sfd_verdict_if and the serial_frame_deframer_crc16 RTL.
module testbench
  import sfd_pkg::*;
();

  localparam int unsigned MinFrameBytes = 12;
  localparam int unsigned RandomBytes = 580;
  localparam int unsigned RandomFrames = 24;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned DrainLimit = 5000;

  // Shapes of frame the stimulus builds. A corrupted frame starts out well formed.
  typedef enum {
    FrGood,      // well formed, CRC correct
    FrBadMagic,  // one magic byte damaged
    FrBadEnd,    // one end marker byte damaged
    FrBadCrc,    // one CRC byte damaged
    FrTrunc,     // cut or padded with random bytes to a given size
    FrFlip,      // one bit flipped anywhere
    FrNoise,     // random bytes only
    FrFill       // every byte the same value
  } frame_e;

  typedef enum {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_e;

  typedef struct packed {
    status_e     status;
    logic        header_valid;
    logic [15:0] payload_len;
    logic [7:0]  priority_res;
    logic [7:0]  msg_id;
    logic [7:0]  sequence_res;
    logic [7:0]  header_flags;
    logic [15:0] rx_crc;
    logic [15:0] computed_crc;
  } frame_verdict_t;

  // One directed frame. The verdict is typed in only where the status alone settles
  // every field (too short, bad magic); other rows go through the frame model.
  typedef struct {
    frame_e      kind;
    int unsigned plen;   // declared payload length, or the fill value
    int unsigned arg;    // damaged byte, or total size
    bit          typed;
    status_e     status;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sfd_byte_if    byte_ch ();
  sfd_verdict_if verdict_ch ();

  serial_frame_deframer_crc16 uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_ch),
    .verdict_o (verdict_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Frame checker model state: one frame in flight at a time.
  logic [16:0] rx_count;
  logic [15:0] crc_run;
  logic [15:0] rx_len;
  logic [31:0] rx_header;
  logic [15:0] rx_crc_field;
  logic        magic_good;
  logic        end_good;
  logic [15:0] crc_at_field;

  frame_verdict_t pending_verdicts[$];
  int unsigned    mismatches = 0;
  idle_e          idle_mode = IdleNone;
  bit             hold_done = 1'b0;
  int unsigned    hold_left = 0;

  frame_row_t directed_frames [18] = '{
    '{FrNoise,    0,     1,       1'b1, StatusShort},   // single byte frame
    '{FrFill,     8'hAA, 1,       1'b1, StatusShort},
    '{FrTrunc,    0,     11,      1'b1, StatusShort},   // one byte under the minimum
    '{FrFill,     8'h00, 12,      1'b1, StatusMagic},
    '{FrFill,     8'hFF, 12,      1'b1, StatusMagic},
    '{FrBadMagic, 0,     0,       1'b1, StatusMagic},
    '{FrBadMagic, 3,     1,       1'b1, StatusMagic},
    '{FrGood,     0,     0,       1'b0, StatusOk},
    '{FrGood,     1,     0,       1'b0, StatusOk},
    '{FrGood,     16,    0,       1'b0, StatusOk},
    '{FrTrunc,    0,     13,      1'b0, StatusOk},      // one byte too many
    '{FrTrunc,    65535, 12,      1'b0, StatusOk},      // largest declared length
    '{FrTrunc,    4,     15,      1'b0, StatusOk},      // shorter than declared
    '{FrBadEnd,   1,     0,       1'b0, StatusOk},
    '{FrBadEnd,   2,     1,       1'b0, StatusOk},
    '{FrBadCrc,   5,     0,       1'b0, StatusOk},
    '{FrBadCrc,   0,     1,       1'b0, StatusOk},
    '{FrTrunc,    300,   60,      1'b0, StatusOk}       // cut far short of a long length
  };

  // CRC16-CCITT-FALSE, one bit at a time, MSB first.
  function automatic logic [15:0] crc16_ccitt_step(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

  task automatic clear_frame_state();
    rx_count = '0;
    crc_run = CrcInit;
    rx_len = '0;
    rx_header = '0;
    rx_crc_field = '0;
    magic_good = 1'b1;
    end_good = 1'b1;
    crc_at_field = '0;
  endtask

  // Advance the frame model by one accepted byte; on the final byte hand back the
  // verdict and return to the idle frame state.
  task automatic deframe_byte(input logic [7:0] b, input logic lst, output bit done,
                              output frame_verdict_t v);
    int unsigned idx;
    int unsigned crc_end;
    int unsigned fsize;
    status_e     st;
    done = 1'b0;
    v = '0;
    idx = rx_count;
    if (idx == 0 && b != Magic0) magic_good = 1'b0;
    if (idx == 1 && b != Magic1) magic_good = 1'b0;
    if (idx == 2) rx_len[7:0] = b;
    if (idx == 3) rx_len[15:8] = b;
    if (idx >= 4 && idx <= 7) rx_header[(idx - 4) * 8 +: 8] = b;

    // Positions after the header follow from the length as captured so far.
    crc_end = int'(CrcOffset) + rx_len;
    if (idx >= 2 && idx < crc_end) crc_run = crc16_ccitt_step(crc_run, b);
    if (idx == crc_end) begin
      crc_at_field = crc_run;
      rx_crc_field[7:0] = b;
    end
    if (idx == crc_end + 1) rx_crc_field[15:8] = b;
    if (idx == crc_end + 2 && b != End0) end_good = 1'b0;
    if (idx == crc_end + 3 && b != End1) end_good = 1'b0;

    // Saturate, not wrap, so an endless frame with good magic reads as a length mismatch.
    if (rx_count != CountMax) rx_count = rx_count + 1'b1;
    if (!lst) return;

    fsize = idx + 1;
    if (fsize < MinFrameBytes) st = StatusShort;
    else if (!magic_good) st = StatusMagic;
    else if (fsize != rx_len + MinFrameBytes) st = StatusLength;
    else if (!end_good) st = StatusEndMark;
    else if (rx_crc_field != crc_at_field) st = StatusCrc;
    else st = StatusOk;

    v.status = st;
    if (st inside {StatusOk, StatusLength, StatusEndMark, StatusCrc}) begin
      v.header_valid = 1'b1;
      v.payload_len = rx_len;
      v.priority_res = rx_header[31:24];
      v.msg_id = rx_header[23:16];
      v.sequence_res = rx_header[15:8];
      v.header_flags = rx_header[7:0];
    end
    if (st inside {StatusOk, StatusCrc}) begin
      v.rx_crc = rx_crc_field;
      v.computed_crc = crc_at_field;
    end
    done = 1'b1;
    clear_frame_state();
  endtask

  // Build a frame: noise or fill as is; else start from a well formed frame, then damage it.
  function automatic void build_frame(frame_e kind, int unsigned plen, int unsigned arg,
                                      ref logic [7:0] q[$]);
    logic [15:0] crc;
    int unsigned pick;
    q = {};
    if (kind == FrNoise || kind == FrFill) begin
      repeat (arg) q.push_back(kind == FrFill ? plen[7:0] : 8'($urandom_range(255)));
      return;
    end
    q.push_back(Magic0);
    q.push_back(Magic1);
    q.push_back(plen[7:0]);
    q.push_back(plen[15:8]);
    repeat (4 + plen) q.push_back(8'($urandom_range(255)));
    crc = CrcInit;
    for (int i = 2; i < q.size(); i++) crc = crc16_ccitt_step(crc, q[i]);
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    q.push_back(End0);
    q.push_back(End1);
    case (kind)
      FrBadMagic: q[arg % 2] ^= 8'($urandom_range(1, 255));
      FrBadEnd:   q[q.size() - 2 + arg % 2] ^= 8'($urandom_range(1, 255));
      FrBadCrc:   q[q.size() - 4 + arg % 2] ^= 8'($urandom_range(1, 255));
      FrFlip: begin
        pick = $urandom_range(q.size() - 1);
        q[pick][$urandom_range(7)] ^= 1'b1;
      end
      FrTrunc: begin
        while (q.size() > arg) void'(q.pop_back());
        while (q.size() < arg) q.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
  endfunction

  // Offer one byte from the falling edge and hold it until a rising edge takes the
  // transaction; then advance the model with what was accepted.
  task automatic send_byte(input logic [7:0] b, input logic lst, output bit done,
                           output frame_verdict_t v);
    @(negedge clk_i);
    while ((idle_mode == IdleSender && $urandom_range(99) < 61) ||
           (idle_mode == IdleBoth && $urandom_range(99) < 8)) begin
      byte_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid = 1'b1;
    byte_ch.data_byte = b;
    byte_ch.last_byte = lst;
    do @(posedge clk_i); while (byte_ch.ready !== 1'b1);
    deframe_byte(b, lst, done, v);
  endtask

  task automatic send_frame(input frame_row_t row, output int unsigned nbytes);
    logic [7:0]     bytes_q[$];
    bit             done;
    frame_verdict_t v;
    build_frame(row.kind, row.plen, row.arg, bytes_q);
    nbytes = bytes_q.size();
    foreach (bytes_q[i]) begin
      send_byte(bytes_q[i], i == bytes_q.size() - 1, done, v);
      if (done) begin
        // A typed-in row carries only a status; every other field of it reads zero.
        if (row.typed) begin
          v = '0;
          v.status = row.status;
        end
        pending_verdicts.push_back(v);
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Drive ready from the falling edge. The first receiver-idle phase starts a long
  // hold-off so finished verdicts back up into the block and stall its input.
  always @(negedge clk_i) begin
    if (idle_mode == IdleReceiver && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      verdict_ch.ready = 1'b0;
      hold_left--;
    end else begin
      case (idle_mode)
        IdleReceiver: verdict_ch.ready = $urandom_range(99) >= 61;
        IdleBoth:     verdict_ch.ready = $urandom_range(99) >= 8;
        default:      verdict_ch.ready = 1'b1;
      endcase
    end
  end

  // Compare every accepted verdict transaction with the oldest outstanding one.
  always @(posedge clk_i) begin
    frame_verdict_t want;
    if (rst_ni && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict with no frame outstanding: status %0d", verdict_ch.status);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 32'(want.status), 32'(verdict_ch.status));
        check_field("header_valid", 32'(want.header_valid), 32'(verdict_ch.header_valid));
        check_field("payload_len", 32'(want.payload_len), 32'(verdict_ch.payload_len));
        check_field("priority_res", 32'(want.priority_res), 32'(verdict_ch.priority_res));
        check_field("msg_id", 32'(want.msg_id), 32'(verdict_ch.msg_id));
        check_field("sequence_res", 32'(want.sequence_res), 32'(verdict_ch.sequence_res));
        check_field("header_flags", 32'(want.header_flags), 32'(verdict_ch.header_flags));
        check_field("rx_crc", 32'(want.rx_crc), 32'(verdict_ch.rx_crc));
        check_field("computed_crc", 32'(want.computed_crc), 32'(verdict_ch.computed_crc));
      end
    end
  end

  initial begin
    frame_row_t  row;
    int unsigned nbytes;
    int unsigned rand_bytes;
    int unsigned rand_frames;
    int unsigned roll;
    int unsigned waited;

    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    clear_frame_state();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames run with no idling on either side.
    foreach (directed_frames[i]) send_frame(directed_frames[i], nbytes);

    // Random frames, mostly well formed or damaged in one place, some pure noise.
    // Step through idle phases by bytes sent; go on until enough bytes and frames are sent.
    rand_bytes = 0;
    rand_frames = 0;
    while (rand_bytes < RandomBytes || rand_frames < RandomFrames) begin
      idle_mode = idle_e'((rand_bytes * 4 / RandomBytes) % 4);
      row.plen = ($urandom_range(9) == 0) ? $urandom_range(11, 80) : $urandom_range(10);
      row.typed = 1'b0;
      row.status = StatusOk;
      roll = $urandom_range(99);
      if (roll < 45) begin
        row.kind = FrGood;
        row.arg = 0;
      end else if (roll < 55) begin
        row.kind = FrBadCrc;
        row.arg = $urandom_range(1);
      end else if (roll < 63) begin
        row.kind = FrBadEnd;
        row.arg = $urandom_range(1);
      end else if (roll < 71) begin
        row.kind = FrBadMagic;
        row.arg = $urandom_range(1);
      end else if (roll < 81) begin
        row.kind = FrTrunc;
        row.arg = $urandom_range(1, row.plen + 15);
      end else if (roll < 91) begin
        row.kind = FrFlip;
        row.arg = 0;
      end else begin
        row.kind = FrNoise;
        row.arg = $urandom_range(1, 20);
      end
      send_frame(row, nbytes);
      rand_bytes += nbytes;
      rand_frames++;
    end

    // Release both sides, drain what is outstanding, then give the pipeline time to
    // show any stray verdict.
    @(negedge clk_i);
    byte_ch.valid = 1'b0;
    idle_mode = IdleNone;
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", pending_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("serial_frame_deframer_crc16: match");
    end else begin
      $display("serial_frame_deframer_crc16: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(8 * 100000);
    $display("serial_frame_deframer_crc16: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sfd_pkg.sv
rtl/sfd_byte_if.sv
rtl/sfd_verdict_if.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/serial_frame_deframer_crc16.sv
test/testbench.sv
